// File: hdl/sorted_timer_task_queue_macros.svh
// Assertion macros for the sorted timer task queue.
`ifndef SORTED_TIMER_TASK_QUEUE_MACROS_SVH
`define SORTED_TIMER_TASK_QUEUE_MACROS_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define STQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/stq_pkg.sv
// Package with types and constants of the sorted timer task queue.
package stq_pkg;
	localparam int TASK_SLOTS_DEF  = 16;
	localparam int MAX_WAIT_US_DEF = 10000;
	localparam int US_PER_MS       = 1000;
	localparam int TIME_W          = 48;
	localparam int MS_W            = 32;
	localparam int ID_W            = 4;
	localparam int WAIT_W          = 14;
	localparam int CNT_W           = 5;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_STOP   = 2'd1,
		CMD_POLL   = 2'd2,
		CMD_FINISH = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MUL,
		ST_SUM,
		ST_INS_RD,
		ST_INS_DL,
		ST_INS_CMP,
		ST_RM_RD,
		ST_RM_CHK,
		ST_POLL_RD,
		ST_POLL_DL,
		ST_POLL_CMP,
		ST_HEAD_RD,
		ST_HEAD_DL,
		ST_WAIT
	} state_t;
endpackage

// File: hdl/sorted_timer_task_queue.sv
// Top level of the sorted timer task queue.
//  channel  direction  content
//  s_axis   in         tdata: cmd, task_id, delay_ms, period_ms, now_us
//  m_axis   out        tdata: accepted, expired_valid, expired_task, pending_count, wait_us
// One item at a time. An item's result waits on the entry-by-entry shift of the order
// memory on insert and removal.
// Reset clears the queue length, pending flags and periods at once.
// The next item is taken in the cycle after the result leaves;
// a stalled output holds its result and blocks new items.
`include "sorted_timer_task_queue_macros.svh"
module sorted_timer_task_queue #(
	parameter int TASK_SLOTS  = stq_pkg::TASK_SLOTS_DEF,
	parameter int MAX_WAIT_US = stq_pkg::MAX_WAIT_US_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cmd[1:0], task_id[5:2], delay_ms[37:6], period_ms[69:38], now_us[117:70], zeros
	input  logic [119:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// accepted[0], expired_valid[1], expired_task[5:2], pending_count[10:6],
	// wait_us[24:11], zeros
	output logic [31:0]  m_axis_tdata
);
	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int LW = $clog2(TASK_SLOTS + 1);
	localparam int PW = stq_pkg::MS_W + 10;
	localparam logic [stq_pkg::TIME_W-1:0] TMAX = {stq_pkg::TIME_W{1'b1}};

	stq_pkg::state_t state_q, state_d;

	logic [IW-1:0]               order_mem [TASK_SLOTS];
	logic [stq_pkg::TIME_W-1:0]  dl_mem    [TASK_SLOTS];
	logic [stq_pkg::MS_W-1:0]    period_q  [TASK_SLOTS];
	logic [TASK_SLOTS-1:0]       pend_q;
	logic [LW-1:0]               len_q;

	stq_pkg::cmd_t               cmd_q;
	logic [stq_pkg::ID_W-1:0]    id_q;
	logic [stq_pkg::MS_W-1:0]    dly_q, per_q, ms_q;
	logic [stq_pkg::TIME_W-1:0]  now_q, when_q, dl_rd_q;
	logic [IW-1:0]               ord_rd_q;
	logic [LW-1:0]               k_q;
	logic                        acc_q, ev_q, found_q;
	logic [stq_pkg::ID_W-1:0]    et_q;
	logic [PW-1:0]               prod_q;
	logic                        ovalid_q;
	logic [31:0]                 odata_q;

	logic [IW-1:0]               id_ix;
	logic                        id_ok, pend_id, full, later, due;
	logic [stq_pkg::MS_W-1:0]    per_id;
	logic [stq_pkg::TIME_W:0]    sum_w;
	logic [stq_pkg::TIME_W-1:0]  diff_w;
	logic [stq_pkg::WAIT_W-1:0]  wait_w;

	logic [IW-1:0]               oaddr, daddr;
	logic                        owe, dwe;
	logic [IW-1:0]               owaddr, owdata;

	assign id_ix   = IW'(id_q);
	assign id_ok   = (32'(id_q) < TASK_SLOTS);
	assign pend_id = pend_q[id_ix];
	assign per_id  = period_q[id_ix];
	assign full    = (len_q >= LW'(TASK_SLOTS));
	assign later   = (dl_rd_q > when_q);
	assign due     = (dl_rd_q <= now_q);
	assign sum_w   = {1'b0, now_q} + (stq_pkg::TIME_W+1)'(prod_q);
	assign diff_w  = dl_rd_q - now_q;

	assign s_axis_tready = (state_q == stq_pkg::ST_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;

	always_comb begin
		if (len_q == '0) wait_w = stq_pkg::WAIT_W'(MAX_WAIT_US);
		else if (dl_rd_q > now_q)
			wait_w = (diff_w > stq_pkg::TIME_W'(MAX_WAIT_US)) ?
				stq_pkg::WAIT_W'(MAX_WAIT_US) : stq_pkg::WAIT_W'(diff_w);
		else wait_w = '0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stq_pkg::ST_IDLE:    if (s_axis_tvalid && s_axis_tready) state_d = stq_pkg::ST_DECIDE;
			stq_pkg::ST_DECIDE: begin
				unique case (cmd_q)
					stq_pkg::CMD_START:
						state_d = (id_ok && !pend_id && !full) ?
							stq_pkg::ST_MUL : stq_pkg::ST_HEAD_RD;
					stq_pkg::CMD_STOP:
						state_d = (id_ok && pend_id) ? stq_pkg::ST_RM_RD : stq_pkg::ST_HEAD_RD;
					stq_pkg::CMD_POLL:
						state_d = (len_q != '0) ? stq_pkg::ST_POLL_RD : stq_pkg::ST_HEAD_RD;
					stq_pkg::CMD_FINISH:
						state_d = (id_ok && !pend_id && per_id != '0 && !full) ?
							stq_pkg::ST_MUL : stq_pkg::ST_HEAD_RD;
				endcase
			end
			stq_pkg::ST_MUL:      state_d = stq_pkg::ST_SUM;
			stq_pkg::ST_SUM:      state_d = stq_pkg::ST_INS_RD;
			stq_pkg::ST_INS_RD:
				state_d = (k_q == '0) ? stq_pkg::ST_HEAD_RD : stq_pkg::ST_INS_DL;
			stq_pkg::ST_INS_DL:   state_d = stq_pkg::ST_INS_CMP;
			stq_pkg::ST_INS_CMP:  state_d = later ? stq_pkg::ST_INS_RD : stq_pkg::ST_HEAD_RD;
			stq_pkg::ST_RM_RD:    state_d = stq_pkg::ST_RM_CHK;
			stq_pkg::ST_RM_CHK:
				state_d = (k_q + LW'(1) >= len_q) ? stq_pkg::ST_HEAD_RD : stq_pkg::ST_RM_RD;
			stq_pkg::ST_POLL_RD:  state_d = stq_pkg::ST_POLL_DL;
			stq_pkg::ST_POLL_DL:  state_d = stq_pkg::ST_POLL_CMP;
			stq_pkg::ST_POLL_CMP:
				state_d = (due && len_q > LW'(1)) ? stq_pkg::ST_RM_RD : stq_pkg::ST_HEAD_RD;
			stq_pkg::ST_HEAD_RD:  state_d = stq_pkg::ST_HEAD_DL;
			stq_pkg::ST_HEAD_DL:  state_d = stq_pkg::ST_WAIT;
			stq_pkg::ST_WAIT:     state_d = stq_pkg::ST_IDLE;
			default:              state_d = stq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		oaddr  = '0;
		daddr  = ord_rd_q;
		owe    = 1'b0;
		dwe    = 1'b0;
		owaddr = IW'(k_q);
		owdata = ord_rd_q;
		unique case (state_q)
			stq_pkg::ST_INS_RD: begin
				oaddr = IW'(k_q - LW'(1));
				if (k_q == '0) begin
					owe    = 1'b1;
					dwe    = 1'b1;
					owdata = id_ix;
				end
			end
			stq_pkg::ST_INS_DL: oaddr = IW'(k_q - LW'(1));
			stq_pkg::ST_INS_CMP: begin
				owe = 1'b1;
				if (!later) begin
					dwe    = 1'b1;
					owdata = id_ix;
				end
			end
			stq_pkg::ST_RM_RD: oaddr = IW'(k_q);
			stq_pkg::ST_RM_CHK: begin
				owe    = found_q;
				owaddr = IW'(k_q - LW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		ord_rd_q <= order_mem[oaddr];
		dl_rd_q  <= dl_mem[daddr];
		if (owe) order_mem[owaddr] <= owdata;
		if (dwe) dl_mem[id_ix] <= when_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= stq_pkg::ST_IDLE;
			pend_q   <= '0;
			len_q    <= '0;
			ovalid_q <= 1'b0;
			odata_q  <= '0;
			cmd_q    <= stq_pkg::CMD_START;
			id_q     <= '0;
			dly_q    <= '0;
			per_q    <= '0;
			ms_q     <= '0;
			now_q    <= '0;
			when_q   <= '0;
			k_q      <= '0;
			acc_q    <= 1'b0;
			ev_q     <= 1'b0;
			found_q  <= 1'b0;
			et_q     <= '0;
			prod_q   <= '0;
			for (int i = 0; i < TASK_SLOTS; i++) period_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == stq_pkg::ST_WAIT) begin
				ovalid_q <= 1'b1;
				odata_q  <= {7'd0, wait_w, stq_pkg::CNT_W'(len_q), et_q, ev_q, acc_q};
			end else if (ovalid_q && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				stq_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					cmd_q <= stq_pkg::cmd_t'(s_axis_tdata[1:0]);
					id_q  <= s_axis_tdata[5:2];
					dly_q <= s_axis_tdata[37:6];
					per_q <= s_axis_tdata[69:38];
					now_q <= s_axis_tdata[117:70];
					acc_q <= 1'b1;
					ev_q  <= 1'b0;
					et_q  <= '0;
				end
				stq_pkg::ST_DECIDE: begin
					unique case (cmd_q)
						stq_pkg::CMD_START: begin
							if (!id_ok || pend_id) acc_q <= 1'b0;
							else begin
								period_q[id_ix] <= per_q;
								ms_q <= dly_q;
							end
						end
						stq_pkg::CMD_STOP: begin
							if (!id_ok) acc_q <= 1'b0;
							else begin
								period_q[id_ix] <= '0;
								pend_q[id_ix]   <= 1'b0;
								found_q <= 1'b0;
								k_q     <= '0;
							end
						end
						stq_pkg::CMD_POLL: ;
						stq_pkg::CMD_FINISH: begin
							if (!id_ok) acc_q <= 1'b0;
							else ms_q <= per_id;
						end
					endcase
				end
				stq_pkg::ST_MUL: prod_q <= PW'(ms_q) * PW'(stq_pkg::US_PER_MS);
				stq_pkg::ST_SUM: begin
					when_q <= sum_w[stq_pkg::TIME_W] ? TMAX : sum_w[stq_pkg::TIME_W-1:0];
					k_q    <= len_q;
				end
				stq_pkg::ST_INS_RD: if (k_q == '0) begin
					pend_q[id_ix] <= 1'b1;
					len_q <= len_q + LW'(1);
				end
				stq_pkg::ST_INS_CMP: begin
					if (later) k_q <= k_q - LW'(1);
					else begin
						pend_q[id_ix] <= 1'b1;
						len_q <= len_q + LW'(1);
					end
				end
				stq_pkg::ST_RM_CHK: begin
					if (!found_q && ord_rd_q == id_ix) found_q <= 1'b1;
					if (k_q + LW'(1) >= len_q) len_q <= len_q - LW'(1);
					else k_q <= k_q + LW'(1);
				end
				stq_pkg::ST_POLL_CMP: if (due) begin
					ev_q <= 1'b1;
					et_q <= stq_pkg::ID_W'(ord_rd_q);
					pend_q[ord_rd_q] <= 1'b0;
					if (len_q == LW'(1)) len_q <= len_q - LW'(1);
					else begin
						found_q <= 1'b1;
						k_q     <= LW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	`STQ_ASSERT_IMP(a_len_max, clk, arst_n, 1'b1, len_q <= LW'(TASK_SLOTS))
	`STQ_ASSERT_IMP(a_ready_idle, clk, arst_n, s_axis_tready, !ovalid_q)
	`STQ_ASSERT_NEXT(a_out_hold, clk, arst_n, ovalid_q && !m_axis_tready, ovalid_q && $stable(odata_q))
endmodule

// File: tb/sv/tb_sorted_timer_task_queue.sv
// Testbench for the sorted timer task queue: directed and random timer commands checked against a model.
module tb_sorted_timer_task_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [47:0] TIME_SAT = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [13:0] wait_us;
		logic [4:0]  pending_count;
		logic [3:0]  expired_task;
		logic        expired_valid;
		logic        accepted;
	} timer_result_t;

	class timer_scoreboard;
		logic [3:0]  order_ids[16];
		int          queue_len;
		logic [47:0] deadline[16];
		logic [31:0] period[16];
		bit          pending[16];
		timer_result_t expected_results[$];
		int          errors;

		function new();
			queue_len = 0;
			errors = 0;
			for (int k = 0; k < 16; k++) begin
				period[k] = '0;
				pending[k] = 0;
				deadline[k] = '0;
				order_ids[k] = '0;
			end
		endfunction

		function logic [47:0] sat_sum(logic [47:0] now, logic [31:0] ms);
			logic [63:0] s;
			s = {16'd0, now} + 64'(ms) * 64'(stq_pkg::US_PER_MS);
			return (s > {16'd0, TIME_SAT}) ? TIME_SAT : s[47:0];
		endfunction

		function void insert_task(int id, logic [47:0] when);
			int pos;
			pos = 0;
			if (queue_len >= 16) return;
			while (pos < queue_len && deadline[order_ids[pos]] <= when) pos++;
			for (int k = queue_len; k > pos; k--) order_ids[k] = order_ids[k - 1];
			order_ids[pos] = id[3:0];
			deadline[id] = when;
			pending[id] = 1;
			queue_len++;
		endfunction

		function void remove_at(int pos);
			pending[order_ids[pos]] = 0;
			for (int k = pos; k + 1 < queue_len; k++) order_ids[k] = order_ids[k + 1];
			queue_len--;
		endfunction

		function void note_command(stq_pkg::cmd_t cmd, logic [3:0] id, logic [31:0] dly,
				logic [31:0] per, logic [47:0] now);
			timer_result_t r;
			logic [47:0] head;
			r = '0;
			r.accepted = 1;
			case (cmd)
				stq_pkg::CMD_START: begin
					if (pending[id]) r.accepted = 0;
					else begin
						period[id] = per;
						insert_task(id, sat_sum(now, dly));
					end
				end
				stq_pkg::CMD_STOP: begin
					period[id] = '0;
					for (int k = 0; k < queue_len; k++)
						if (order_ids[k] == id) begin
							remove_at(k);
							break;
						end
				end
				stq_pkg::CMD_POLL: begin
					if (queue_len > 0 && deadline[order_ids[0]] <= now) begin
						r.expired_valid = 1;
						r.expired_task = order_ids[0];
						remove_at(0);
					end
				end
				default: begin
					if (!pending[id] && period[id] != 0)
						insert_task(id, sat_sum(now, period[id]));
				end
			endcase
			r.pending_count = queue_len[4:0];
			if (queue_len == 0) r.wait_us = 14'(stq_pkg::MAX_WAIT_US_DEF);
			else begin
				head = deadline[order_ids[0]];
				if (head > now)
					r.wait_us = (head - now > 48'(stq_pkg::MAX_WAIT_US_DEF)) ?
						14'(stq_pkg::MAX_WAIT_US_DEF) : 14'(head - now);
				else r.wait_us = '0;
			end
			expected_results.push_back(r);
		endfunction

		task check_result(timer_result_t got);
			timer_result_t e;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", 0, got);
				return;
			end
			e = expected_results.pop_front();
			if (got.accepted !== e.accepted)
				report_mismatch("accepted", e.accepted, got.accepted);
			if (got.expired_valid !== e.expired_valid)
				report_mismatch("expired_valid", e.expired_valid, got.expired_valid);
			if (got.expired_task !== e.expired_task)
				report_mismatch("expired_task", e.expired_task, got.expired_task);
			if (got.pending_count !== e.pending_count)
				report_mismatch("pending_count", e.pending_count, got.pending_count);
			if (got.wait_us !== e.wait_us)
				report_mismatch("wait_us", e.wait_us, got.wait_us);
		endtask

		task report_mismatch(string what, longint unsigned want,
				longint unsigned got);
			$display("MISMATCH %s: expected %0d got %0d", what, want, got);
			errors++;
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [31:0]  m_axis_tdata;

	timer_scoreboard sb;
	int  send_idle_pct = 30;
	int  recv_idle_pct = 63;
	bit  recv_hold = 0;
	logic [47:0] now_clock = 48'd0;

	always #5 clk = ~clk;

	sorted_timer_task_queue u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(timer_result_t'(m_axis_tdata[24:0]));
		m_axis_tready <= arst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_command(stq_pkg::cmd_t cmd, logic [3:0] id, logic [31:0] dly,
			logic [31:0] per, logic [47:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {2'b00, now, per, dly, id, cmd};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_command(cmd, id, dly, per, now);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (sb.expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_ms();
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF;
			2, 3: return 32'd0;
			default: return $urandom_range(12);
		endcase
	endfunction

	task automatic random_phase(int count);
		int c;
		for (int i = 0; i < count; i++) begin
			c = $urandom_range(99);
			if ($urandom_range(19) == 0) now_clock = 48'({$urandom(), $urandom()});
			else now_clock = now_clock + 48'($urandom_range(4000));
			if (c < 35)
				send_command(stq_pkg::CMD_START, 4'($urandom_range(15)), pick_ms(), pick_ms(),
					now_clock);
			else if (c < 45)
				send_command(stq_pkg::CMD_STOP, 4'($urandom_range(15)), $urandom(), $urandom(),
					now_clock);
			else if (c < 80)
				send_command(stq_pkg::CMD_POLL, 4'($urandom_range(15)), $urandom(), $urandom(),
					now_clock);
			else
				send_command(stq_pkg::CMD_FINISH, 4'($urandom_range(15)), $urandom(), $urandom(),
					now_clock);
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		send_command(stq_pkg::CMD_POLL, 4'd0, 32'd0, 32'd0, 48'd0);
		send_command(stq_pkg::CMD_START, 4'd0, 32'd0, 32'd1, 48'd100);
		send_command(stq_pkg::CMD_START, 4'd0, 32'd5, 32'd5, 48'd100);
		send_command(stq_pkg::CMD_START, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_SAT);
		send_command(stq_pkg::CMD_START, 4'd7, 32'd0, 32'd0, 48'd100);
		send_command(stq_pkg::CMD_START, 4'd3, 32'd20, 32'd0, 48'd100);
		send_command(stq_pkg::CMD_POLL, 4'd0, 32'd0, 32'd0, 48'd100);
		send_command(stq_pkg::CMD_POLL, 4'd0, 32'd0, 32'd0, 48'd100);
		send_command(stq_pkg::CMD_FINISH, 4'd0, 32'd0, 32'd0, 48'd200);
		send_command(stq_pkg::CMD_FINISH, 4'd7, 32'd0, 32'd0, 48'd200);
		send_command(stq_pkg::CMD_FINISH, 4'd0, 32'd0, 32'd0, 48'd200);
		send_command(stq_pkg::CMD_STOP, 4'd9, 32'd0, 32'd0, 48'd300);
		send_command(stq_pkg::CMD_STOP, 4'd3, 32'd0, 32'd0, 48'd300);
		send_command(stq_pkg::CMD_POLL, 4'd0, 32'd0, 32'd0, TIME_SAT);
		send_command(stq_pkg::CMD_POLL, 4'd0, 32'd0, 32'd0, TIME_SAT);
		send_command(stq_pkg::CMD_POLL, 4'd0, 32'd0, 32'd0, TIME_SAT);
		for (int k = 0; k < 16; k++)
			send_command(stq_pkg::CMD_START, k[3:0], 32'd1, 32'd0, 48'd1000);
		send_command(stq_pkg::CMD_FINISH, 4'd4, 32'd0, 32'd0, 48'd0);
		wait_drained();

		random_phase(400);
		recv_hold = 1;
		fork
			random_phase(20);
			begin
				repeat (300) @(posedge clk);
				recv_hold = 0;
			end
		join
		wait_drained();
		send_idle_pct = 63;
		recv_idle_pct = 30;
		random_phase(400);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(400);

		wait_drained();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
